// ===== rtl/core/acl_pkg.sv =====
// ----------------------------------------------------------------------------
// acl_pkg - shared types and constants for the IP access rule block
// Request codes, verdict codes, register indexes and the interfaces between
// the sequencer, the match unit and the top level.
// ----------------------------------------------------------------------------
package acl_pkg;

  // default table depths
  localparam int V4_RULES_DEF = 64;
  localparam int V6_RULES_DEF = 16;

  // field and register widths
  localparam int MODE_W     = 2;
  localparam int FAMILY_W   = 2;
  localparam int SLOT_W     = 6;
  localparam int HALF_W     = 64;
  localparam int V4_W       = 32;
  localparam int VERDICT_W  = 2;
  localparam int V4_CNT_W   = 7;
  localparam int V6_CNT_W   = 5;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 7;

  // IPv4-mapped IPv6: ::ffff:a.b.c.d, the 16 ones sit just above the v4 part
  localparam logic [V4_W-1:0] MAPPED_TAG = 32'h0000_FFFF;

  // request modes
  typedef enum logic [MODE_W-1:0] {
    MODE_WR_V4  = 2'd0,
    MODE_WR_V6  = 2'd1,
    MODE_LOOKUP = 2'd2,
    MODE_UNUSED = 2'd3
  } acl_mode_t;

  // client families
  typedef enum logic [FAMILY_W-1:0] {
    FAM_V4    = 2'd0,
    FAM_V6    = 2'd1,
    FAM_UNIX  = 2'd2,
    FAM_OTHER = 2'd3
  } acl_family_t;

  // verdict codes
  localparam logic [VERDICT_W-1:0] VERDICT_DECLINED  = 2'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_ALLOWED   = 2'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_FORBIDDEN = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_V4_COUNT    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_V6_COUNT    = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_UNIX_PRESENT = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UNIX_DENY   = 4'd3;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } acl_state_t;

  // 128-bit address or mask as two halves
  typedef struct packed {
    logic [HALF_W-1:0] hi;
    logic [HALF_W-1:0] lo;
  } acl_prefix_t;

  // what a request asks of the sequencer
  typedef struct packed {
    logic                 scan;     // walk a rule table
    logic                 v6;       // walk the IPv6 table
    logic [VERDICT_W-1:0] verdict;  // immediate result when no scan
    logic                 matched;
  } acl_job_t;

  // scan read control from the sequencer
  typedef struct packed {
    logic rd_en;
    logic sel_v6;
  } acl_scan_t;

  // one result
  typedef struct packed {
    logic [VERDICT_W-1:0] verdict;
    logic                 matched;
    logic [SLOT_W-1:0]    match_index;
  } acl_res_t;

endpackage

// ===== rtl/core/acl_ram.sv =====
// ----------------------------------------------------------------------------
// acl_ram - generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module acl_ram #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/acl_match.sv =====
// ----------------------------------------------------------------------------
// acl_match - shared prefix compare unit
// Hit when the masked client address equals the rule address, 128 bits wide.
// IPv4 rules use it with the upper 96 mask and address bits at zero.
// ----------------------------------------------------------------------------
module acl_match (
  input  acl_pkg::acl_prefix_t client,
  input  acl_pkg::acl_prefix_t rule_addr,
  input  acl_pkg::acl_prefix_t rule_mask,
  output logic                 hit
);
  import acl_pkg::*;

  // bits outside the mask in the rule address never match, as intended
  assign hit = ((client.hi & rule_mask.hi) == rule_addr.hi) &&
               ((client.lo & rule_mask.lo) == rule_addr.lo);

endmodule

// ===== rtl/core/acl_ctrl.sv =====
// ----------------------------------------------------------------------------
// acl_ctrl - lookup sequencer
// Walks one rule per cycle through the selected table, stops at the first
// hit, and hands the result to the output register.
// ----------------------------------------------------------------------------
module acl_ctrl #(
  parameter int IW = 7
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start_i,
  input  acl_pkg::acl_job_t  job_i,
  input  logic [IW-1:0]      limit_i,
  input  logic               hit_i,
  input  logic               deny_i,
  input  logic               out_ready_i,
  output logic               idle_o,
  output acl_pkg::acl_scan_t scan_o,
  output logic [IW-1:0]      rd_idx_o,
  output logic               out_valid_o,
  output acl_pkg::acl_res_t  out_res_o
);
  import acl_pkg::*;

  acl_state_t    state_r, state_nxt;
  logic [IW-1:0] rd_idx_r, rd_idx_nxt;
  logic [IW-1:0] pend_idx_r, pend_idx_nxt;
  logic [IW-1:0] limit_r, limit_nxt;
  logic          pend_r, pend_nxt;
  logic          v6_r, v6_nxt;
  acl_res_t      res_r, res_nxt;
  logic          out_valid_r, out_valid_nxt;
  acl_res_t      out_res_r, out_res_nxt;

  logic          rd_en;
  logic          out_free;
  logic          last_pend;

  // compare data for pend_idx_r is on the RAM output this cycle
  assign last_pend = pend_r && (rd_idx_r == limit_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start_i) begin
          state_nxt = job_i.scan ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        if (pend_r && (hit_i || last_pend)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    idle_o        = (state_r == ST_IDLE);
    rd_en         = (state_r == ST_SCAN) && (rd_idx_r != limit_r);
    out_free      = !out_valid_r || out_ready_i;
    scan_o.rd_en  = rd_en;
    scan_o.sel_v6 = v6_r;
    rd_idx_o      = rd_idx_r;
    out_valid_o   = out_valid_r;
    out_res_o     = out_res_r;
  end

  // scan counters and result
  always_comb begin
    rd_idx_nxt    = rd_idx_r;
    pend_idx_nxt  = pend_idx_r;
    limit_nxt     = limit_r;
    pend_nxt      = pend_r;
    v6_nxt        = v6_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;

    if (out_valid_r && out_ready_i) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (start_i) begin
          rd_idx_nxt          = '0;
          pend_nxt            = 1'b0;
          v6_nxt              = job_i.v6;
          limit_nxt           = limit_i;
          res_nxt.verdict     = job_i.verdict;
          res_nxt.matched     = job_i.matched;
          res_nxt.match_index = '0;
        end
      end
      ST_SCAN: begin
        pend_nxt     = rd_en;
        pend_idx_nxt = rd_idx_r;
        if (rd_en) begin
          rd_idx_nxt = IW'(rd_idx_r + 1'b1);
        end
        if (pend_r && hit_i) begin
          res_nxt.verdict     = deny_i ? VERDICT_FORBIDDEN : VERDICT_ALLOWED;
          res_nxt.matched     = 1'b1;
          res_nxt.match_index = SLOT_W'(pend_idx_r);
        end else if (last_pend) begin
          res_nxt.verdict     = VERDICT_DECLINED;
          res_nxt.matched     = 1'b0;
          res_nxt.match_index = '0;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = res_r;
        end
      end
      default: begin
        pend_nxt = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rd_idx_r   <= rd_idx_nxt;
    pend_idx_r <= pend_idx_nxt;
    limit_r    <= limit_nxt;
    v6_r       <= v6_nxt;
    res_r      <= res_nxt;
    out_res_r  <= out_res_nxt;
  end

endmodule

// ===== rtl/core/ip_access_rule_first_match.sv =====
// ----------------------------------------------------------------------------
// ip_access_rule_first_match - IPv4/IPv6/unix access rules, first match wins
// Rule tables in RAM, one shared prefix compare unit, scanned by a sequencer.
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_ready   mode, family, slot, addr, mask, deny
//   out_     output     out_valid / out_ready verdict, matched, match_index
//   cfg_     input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// Writes, unix, declined and unused requests: no table scan; the result goes to the done state.
// Table lookup: the compare unit takes one rule a cycle from the RAM read port;
//   the scan stops at the first hit or after the last configured rule, then the
//   result goes through the done state. The block takes a new request only when idle.
// Reset clears control and config (unix deny comes up set); the rule tables are not cleared.
// A stalled output holds its result; the next request still runs, then waits
//   in the done state until the held result is taken.
// ----------------------------------------------------------------------------
module ip_access_rule_first_match #(
  parameter int V4_RULES = acl_pkg::V4_RULES_DEF,
  parameter int V6_RULES = acl_pkg::V6_RULES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // request channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [acl_pkg::MODE_W-1:0]     in_mode,
  input  logic [acl_pkg::FAMILY_W-1:0]   in_family,
  input  logic [acl_pkg::SLOT_W-1:0]     in_rule_index,
  input  logic [acl_pkg::HALF_W-1:0]     in_address_high,
  input  logic [acl_pkg::HALF_W-1:0]     in_address_low,
  input  logic [acl_pkg::HALF_W-1:0]     in_mask_high,
  input  logic [acl_pkg::HALF_W-1:0]     in_mask_low,
  input  logic                           in_deny_flag,
  // result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [acl_pkg::VERDICT_W-1:0]  out_verdict,
  output logic                           out_matched,
  output logic [acl_pkg::SLOT_W-1:0]     out_match_index,
  // configuration channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [acl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [acl_pkg::CFG_DATA_W-1:0] cfg_data
);
  import acl_pkg::*;

  localparam int MAXR  = (V4_RULES > V6_RULES) ? V4_RULES : V6_RULES;
  localparam int IW    = $clog2(MAXR + 1);
  localparam int V4AW  = (V4_RULES > 1) ? $clog2(V4_RULES) : 1;
  localparam int V6AW  = (V6_RULES > 1) ? $clog2(V6_RULES) : 1;
  localparam int V4DW  = 2 * V4_W + 1;
  localparam int V6DW  = 4 * HALF_W + 1;

  // configuration registers
  logic [V4_CNT_W-1:0] v4_cnt_r;
  logic [V6_CNT_W-1:0] v6_cnt_r;
  logic                unix_present_r;
  logic                unix_deny_r;

  logic                accept;
  logic                we_v4, we_v6;
  logic                mapped;
  acl_job_t            job;
  logic [IW-1:0]       v4_lim, v6_lim, limit;
  logic                idle;
  acl_scan_t           scan;
  logic [IW-1:0]       rd_idx;
  acl_res_t            res;
  acl_prefix_t         cli_r;
  acl_prefix_t         rule_addr, rule_mask;
  logic                hit, deny;
  logic [V4DW-1:0]     v4_rdata;
  logic [V6DW-1:0]     v6_rdata;

  assign cfg_ready = 1'b1;
  assign in_ready  = idle;
  assign accept    = in_valid && in_ready;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_cnt_r       <= '0;
      v6_cnt_r       <= '0;
      unix_present_r <= 1'b0;
      unix_deny_r    <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_V4_COUNT:     v4_cnt_r       <= cfg_data[V4_CNT_W-1:0];
        CFG_V6_COUNT:     v6_cnt_r       <= cfg_data[V6_CNT_W-1:0];
        CFG_UNIX_PRESENT: unix_present_r <= cfg_data[0];
        CFG_UNIX_DENY:    unix_deny_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // rule writes go straight to the tables; out-of-range slots are dropped
  assign we_v4 = accept && (in_mode == MODE_WR_V4) &&
                 (32'(in_rule_index) < 32'(V4_RULES));
  assign we_v6 = accept && (in_mode == MODE_WR_V6) &&
                 (32'(in_rule_index) < 32'(V6_RULES));

  // scan length, saturated at the table depth
  assign v4_lim = (32'(v4_cnt_r) > 32'(V4_RULES)) ? IW'(V4_RULES) : IW'(v4_cnt_r);
  assign v6_lim = (32'(v6_cnt_r) > 32'(V6_RULES)) ? IW'(V6_RULES) : IW'(v6_cnt_r);

  assign mapped = (in_address_high == '0) &&
                  (in_address_low[HALF_W-1:V4_W] == MAPPED_TAG);

  // decode the request into a scan or an immediate result
  always_comb begin
    job.scan    = 1'b0;
    job.v6      = 1'b0;
    job.verdict = VERDICT_DECLINED;
    job.matched = 1'b0;
    limit       = v4_lim;
    case (in_mode)
      MODE_LOOKUP: begin
        case (in_family)
          FAM_V4: begin
            job.scan = (v4_cnt_r != '0);
          end
          FAM_V6: begin
            if (mapped && (v4_cnt_r != '0)) begin
              job.scan = 1'b1;
            end else if (v6_cnt_r != '0) begin
              job.scan = 1'b1;
              job.v6   = 1'b1;
              limit    = v6_lim;
            end
          end
          FAM_UNIX: begin
            if (unix_present_r) begin
              job.matched = 1'b1;
              job.verdict = unix_deny_r ? VERDICT_FORBIDDEN : VERDICT_ALLOWED;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // client address held for the scan
  always_ff @(posedge clk) begin
    if (accept) begin
      cli_r.hi <= in_address_high;
      cli_r.lo <= in_address_low;
    end
  end

  // IPv4 table: {deny, mask, address}
  acl_ram #(
    .WIDTH (V4DW),
    .DEPTH (V4_RULES)
  ) u_v4_ram (
    .clk   (clk),
    .we    (we_v4),
    .waddr (V4AW'(in_rule_index)),
    .wdata ({in_deny_flag, in_mask_low[V4_W-1:0], in_address_low[V4_W-1:0]}),
    .re    (scan.rd_en && !scan.sel_v6),
    .raddr (rd_idx[V4AW-1:0]),
    .rdata (v4_rdata)
  );

  // IPv6 table: {deny, mask hi, mask lo, address hi, address lo}
  acl_ram #(
    .WIDTH (V6DW),
    .DEPTH (V6_RULES)
  ) u_v6_ram (
    .clk   (clk),
    .we    (we_v6),
    .waddr (V6AW'(in_rule_index)),
    .wdata ({in_deny_flag, in_mask_high, in_mask_low, in_address_high, in_address_low}),
    .re    (scan.rd_en && scan.sel_v6),
    .raddr (rd_idx[V6AW-1:0]),
    .rdata (v6_rdata)
  );

  // feed the compare unit from the table being walked
  always_comb begin
    if (scan.sel_v6) begin
      rule_mask.hi = v6_rdata[4*HALF_W-1:3*HALF_W];
      rule_mask.lo = v6_rdata[3*HALF_W-1:2*HALF_W];
      rule_addr.hi = v6_rdata[2*HALF_W-1:HALF_W];
      rule_addr.lo = v6_rdata[HALF_W-1:0];
      deny         = v6_rdata[V6DW-1];
    end else begin
      rule_mask.hi = '0;
      rule_mask.lo = {{(HALF_W-V4_W){1'b0}}, v4_rdata[2*V4_W-1:V4_W]};
      rule_addr.hi = '0;
      rule_addr.lo = {{(HALF_W-V4_W){1'b0}}, v4_rdata[V4_W-1:0]};
      deny         = v4_rdata[V4DW-1];
    end
  end

  acl_match u_match (
    .client    (cli_r),
    .rule_addr (rule_addr),
    .rule_mask (rule_mask),
    .hit       (hit)
  );

  acl_ctrl #(
    .IW (IW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start_i     (accept),
    .job_i       (job),
    .limit_i     (limit),
    .hit_i       (hit),
    .deny_i      (deny),
    .out_ready_i (out_ready),
    .idle_o      (idle),
    .scan_o      (scan),
    .rd_idx_o    (rd_idx),
    .out_valid_o (out_valid),
    .out_res_o   (res)
  );

  assign out_verdict     = res.verdict;
  assign out_matched     = res.matched;
  assign out_match_index = res.match_index;

`ifndef SYNTH
  // a result without a match is always a plain decline
  a_nomatch_declined: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_matched |-> out_verdict == VERDICT_DECLINED && out_match_index == '0)
    else $error("unmatched result carries a verdict or index");

  // a match always decides allowed or forbidden
  a_match_decides: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_matched |-> out_verdict == VERDICT_ALLOWED ||
                                 out_verdict == VERDICT_FORBIDDEN)
    else $error("matched result without a decision");

  // an accepted request keeps the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ready)
    else $error("request accepted while previous one still in flight");

  // table reads only happen while no request is being taken
  a_scan_busy: assert property (@(posedge clk) disable iff (!rst_n)
    scan.rd_en |-> !in_ready && !we_v4 && !we_v6)
    else $error("table read overlaps a request");
`endif

endmodule

// ===== test/ip_access_rule_first_match_tb.sv =====
// ----------------------------------------------------------------------------
// ip_access_rule_first_match_tb - self-checking bench for the access rule block
// Loads the IPv4 and IPv6 rule tables, steps through several register
// settings and checks every result, field by field, against a first-match
// predictor. Both channels idle at random; the result side also stalls for
// long stretches so that request acceptance backs up.
// ----------------------------------------------------------------------------
module ip_access_rule_first_match_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import acl_pkg::*;

  localparam int V4_N            = V4_RULES_DEF;
  localparam int V6_N            = V6_RULES_DEF;
  localparam int SCAN_SLACK      = V4_N + 8;      // longest scan plus pipeline
  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int PHASES          = 10;
  localparam int ITEMS_PER_PHASE = 165;
  localparam int IDLE_PCT        = 27;
  localparam int QUIET_LO        = 900;           // no idling in this request window
  localparam int QUIET_HI        = 1100;
  localparam int HOLD_EVERY      = 600;           // long result stall every N requests
  localparam int HOLD_LEN        = 400;

  // index with no register behind it, writes must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 4'd15;

  typedef struct {
    acl_mode_t         mode;
    acl_family_t       family;
    logic [SLOT_W-1:0] slot;
    logic [HALF_W-1:0] ahi;
    logic [HALF_W-1:0] alo;
    logic [HALF_W-1:0] mhi;
    logic [HALF_W-1:0] mlo;
    logic              deny;
  } acl_req_t;

  // clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // request channel
  logic                 in_valid        = 1'b0;
  logic                 in_ready;
  logic [MODE_W-1:0]    in_mode         = '0;
  logic [FAMILY_W-1:0]  in_family       = '0;
  logic [SLOT_W-1:0]    in_rule_index   = '0;
  logic [HALF_W-1:0]    in_address_high = '0;
  logic [HALF_W-1:0]    in_address_low  = '0;
  logic [HALF_W-1:0]    in_mask_high    = '0;
  logic [HALF_W-1:0]    in_mask_low     = '0;
  logic                 in_deny_flag    = 1'b0;

  // result channel
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [VERDICT_W-1:0] out_verdict;
  logic                 out_matched;
  logic [SLOT_W-1:0]    out_match_index;

  // configuration channel
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // predictor state: rule tables and registers
  logic [V4_W-1:0]      v4_addr    [V4_N];
  logic [V4_W-1:0]      v4_mask    [V4_N];
  logic                 v4_deny    [V4_N];
  logic [HALF_W-1:0]    v6_addr_hi [V6_N];
  logic [HALF_W-1:0]    v6_addr_lo [V6_N];
  logic [HALF_W-1:0]    v6_mask_hi [V6_N];
  logic [HALF_W-1:0]    v6_mask_lo [V6_N];
  logic                 v6_deny    [V6_N];
  logic [V4_CNT_W-1:0]  v4_count;
  logic [V6_CNT_W-1:0]  v6_count;
  logic                 unix_present;
  logic                 unix_deny;

  // bench bookkeeping
  acl_req_t requests_todo[$];
  acl_res_t verdicts_due[$];
  acl_req_t on_wire;
  int       n_queued   = 0;
  int       n_accepted = 0;
  int       n_errors   = 0;
  int       cycles     = 0;
  int       hold_left  = 0;
  int       hold_mark  = 0;

  ip_access_rule_first_match dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_family       (in_family),
    .in_rule_index   (in_rule_index),
    .in_address_high (in_address_high),
    .in_address_low  (in_address_low),
    .in_mask_high    (in_mask_high),
    .in_mask_low     (in_mask_low),
    .in_deny_flag    (in_deny_flag),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_verdict     (out_verdict),
    .out_matched     (out_matched),
    .out_match_index (out_match_index),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------
  function automatic acl_res_t rule_verdict(logic deny, int idx);
    acl_res_t r;
    r.verdict     = deny ? VERDICT_FORBIDDEN : VERDICT_ALLOWED;
    r.matched     = 1'b1;
    r.match_index = SLOT_W'(idx);
    return r;
  endfunction

  function automatic acl_res_t scan_v4(logic [V4_W-1:0] client);
    acl_res_t r;
    int       n;
    logic     hit;
    r   = '0;
    hit = 1'b0;
    n   = (v4_count > V4_N) ? V4_N : int'(v4_count);
    for (int k = 0; k < n; k++) begin
      if (!hit && (client & v4_mask[k]) == v4_addr[k]) begin
        hit = 1'b1;
        r   = rule_verdict(v4_deny[k], k);
      end
    end
    return r;
  endfunction

  function automatic acl_res_t scan_v6(logic [HALF_W-1:0] hi, logic [HALF_W-1:0] lo);
    acl_res_t r;
    int       n;
    logic     hit;
    r   = '0;
    hit = 1'b0;
    n   = (v6_count > V6_N) ? V6_N : int'(v6_count);
    for (int k = 0; k < n; k++) begin
      if (!hit && (hi & v6_mask_hi[k]) == v6_addr_hi[k] &&
          (lo & v6_mask_lo[k]) == v6_addr_lo[k]) begin
        hit = 1'b1;
        r   = rule_verdict(v6_deny[k], k);
      end
    end
    return r;
  endfunction

  // applies one request to the tables and returns its result
  function automatic acl_res_t judge_request(acl_req_t q);
    acl_res_t r;
    logic     mapped;
    r        = '0;
    r.verdict = VERDICT_DECLINED;
    mapped   = (q.ahi == '0) && (q.alo[HALF_W-1:V4_W] == MAPPED_TAG);
    case (q.mode)
      MODE_WR_V4: begin
        if (q.slot < V4_N) begin
          v4_addr[q.slot] = q.alo[V4_W-1:0];
          v4_mask[q.slot] = q.mlo[V4_W-1:0];
          v4_deny[q.slot] = q.deny;
        end
      end
      MODE_WR_V6: begin
        if (q.slot < V6_N) begin
          v6_addr_hi[q.slot] = q.ahi;
          v6_addr_lo[q.slot] = q.alo;
          v6_mask_hi[q.slot] = q.mhi;
          v6_mask_lo[q.slot] = q.mlo;
          v6_deny[q.slot]    = q.deny;
        end
      end
      MODE_LOOKUP: begin
        case (q.family)
          FAM_V4: begin
            if (v4_count != 0) r = scan_v4(q.alo[V4_W-1:0]);
          end
          FAM_V6: begin
            // mapped clients fall back to the IPv6 table only when no IPv4 rules are set
            if (mapped && v4_count != 0) r = scan_v4(q.alo[V4_W-1:0]);
            else if (v6_count != 0) r = scan_v6(q.ahi, q.alo);
          end
          FAM_UNIX: begin
            if (unix_present) r = rule_verdict(unix_deny, 0);
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // request generation
  // ---------------------------------------------------------------------------
  function automatic logic [HALF_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [127:0] prefix128(int len);
    return (len == 0) ? '0 : ({128{1'b1}} << (128 - len));
  endfunction

  function automatic acl_req_t rand_req();
    acl_req_t q;
    q.mode   = acl_mode_t'($urandom_range(3));
    q.family = acl_family_t'($urandom_range(3));
    q.slot   = SLOT_W'($urandom_range(63));
    q.ahi    = rand64();
    q.alo    = rand64();
    q.mhi    = rand64();
    q.mlo    = rand64();
    q.deny   = 1'($urandom_range(1));
    return q;
  endfunction

  function automatic acl_req_t rule_at(acl_mode_t mode, logic [SLOT_W-1:0] slot,
                                       logic [HALF_W-1:0] ahi, logic [HALF_W-1:0] alo,
                                       logic [HALF_W-1:0] mhi, logic [HALF_W-1:0] mlo,
                                       logic deny);
    acl_req_t q;
    q      = rand_req();
    q.mode = mode;
    q.slot = slot;
    q.ahi  = ahi;
    q.alo  = alo;
    q.mhi  = mhi;
    q.mlo  = mlo;
    q.deny = deny;
    return q;
  endfunction

  function automatic acl_req_t lookup_at(acl_family_t fam, logic [HALF_W-1:0] hi,
                                         logic [HALF_W-1:0] lo);
    acl_req_t q;
    q        = rand_req();
    q.mode   = MODE_LOOKUP;
    q.family = fam;
    q.ahi    = hi;
    q.alo    = lo;
    return q;
  endfunction

  // rule write with a mostly CIDR-shaped mask
  function automatic acl_req_t make_rule(logic v6, logic [SLOT_W-1:0] slot);
    acl_req_t     q;
    logic [127:0] m;
    int           kind;
    q      = rand_req();
    q.mode = v6 ? MODE_WR_V6 : MODE_WR_V4;
    q.slot = slot;
    kind   = $urandom_range(19);
    if (kind == 0) m = {rand64(), rand64()};                     // scattered mask
    else if (kind == 1 && slot >= (v6 ? 12 : 48)) m = '0;         // catch-all, late slots only
    else m = prefix128(v6 ? $urandom_range(16, 128) : $urandom_range(8, 32));
    if (v6) begin
      q.mhi = m[127:64];
      q.mlo = m[63:0];
    end else begin
      q.mlo[V4_W-1:0] = m[127:96];
    end
    // kind 2 keeps address bits outside the mask: such a rule hits only if those bits are zero
    if (kind != 2) begin
      q.ahi &= q.mhi;
      q.alo &= q.mlo;
    end
    return q;
  endfunction

  // lookup, mostly aimed at a rule inside the scanned range
  function automatic acl_req_t make_lookup();
    acl_req_t        q;
    logic [V4_W-1:0] c4;
    int              pick, n4, n6, k4, k6, b;
    q      = rand_req();
    q.mode = MODE_LOOKUP;
    n4     = (v4_count == 0) ? 1 : ((v4_count > V4_N) ? V4_N : int'(v4_count));
    n6     = (v6_count == 0) ? 1 : ((v6_count > V6_N) ? V6_N : int'(v6_count));
    k4     = $urandom_range(n4 - 1);
    k6     = $urandom_range(n6 - 1);
    c4     = $urandom;
    if ($urandom_range(9) < 7) c4 = (v4_addr[k4] & v4_mask[k4]) | (c4 & ~v4_mask[k4]);
    pick = $urandom_range(99);
    if (pick < 45) begin
      q.family        = FAM_V4;
      q.alo[V4_W-1:0] = c4;
    end else if (pick < 60) begin
      q.family = FAM_V6;
      q.ahi    = '0;
      q.alo    = {MAPPED_TAG, c4};
      // now and then spoil the mapped tag by one bit
      if ($urandom_range(7) == 0) begin
        b        = $urandom_range(HALF_W - 1, V4_W);
        q.alo[b] = ~q.alo[b];
      end
    end else if (pick < 85) begin
      q.family = FAM_V6;
      if ($urandom_range(9) < 7) begin
        q.ahi = (v6_addr_hi[k6] & v6_mask_hi[k6]) | (q.ahi & ~v6_mask_hi[k6]);
        q.alo = (v6_addr_lo[k6] & v6_mask_lo[k6]) | (q.alo & ~v6_mask_lo[k6]);
      end
    end else if (pick < 93) begin
      q.family = FAM_UNIX;
    end else begin
      q.family = FAM_OTHER;
    end
    return q;
  endfunction

  function automatic bit roll_idle();
    return !(n_accepted >= QUIET_LO && n_accepted < QUIET_HI) &&
           ($urandom_range(99) < IDLE_PCT);
  endfunction

  task automatic queue_req(acl_req_t q);
    requests_todo.push_back(q);
    n_queued++;
  endtask

  task automatic note_mismatch(string msg);
    if (n_errors < 100) $display("mismatch: %s", msg);
    n_errors++;
  endtask

  // register write; only called while the block is idle
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_V4_COUNT:     v4_count     = data[V4_CNT_W-1:0];
      CFG_V6_COUNT:     v6_count     = data[V6_CNT_W-1:0];
      CFG_UNIX_PRESENT: unix_present = data[0];
      CFG_UNIX_DENY:    unix_deny    = data[0];
      default: ;
    endcase
  endtask

  // every request taken, every result back, then let the scan pipe settle
  task automatic wait_idle();
    while (n_accepted != n_queued || verdicts_due.size() != 0) @(posedge clk);
    repeat (SCAN_SLACK) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // request driver
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : feed_requests
    acl_req_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        verdicts_due.push_back(judge_request(on_wire));
        n_accepted <= n_accepted + 1;
      end
      if (!in_valid || in_ready) begin
        if (requests_todo.size() != 0 && !roll_idle()) begin
          nxt             = requests_todo.pop_front();
          on_wire         = nxt;
          in_mode         <= nxt.mode;
          in_family       <= nxt.family;
          in_rule_index   <= nxt.slot;
          in_address_high <= nxt.ahi;
          in_address_low  <= nxt.alo;
          in_mask_high    <= nxt.mhi;
          in_mask_low     <= nxt.mlo;
          in_deny_flag    <= nxt.deny;
          in_valid        <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // long result stall: fills the block while requests keep coming
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_mark <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (n_accepted >= hold_mark + HOLD_EVERY) begin
      hold_left <= HOLD_LEN;
      hold_mark <= n_accepted;
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch_results
    acl_res_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (verdicts_due.size() == 0) begin
          note_mismatch($sformatf("unexpected result, verdict %0d", out_verdict));
        end else begin
          want = verdicts_due.pop_front();
          if (out_verdict !== want.verdict)
            note_mismatch($sformatf("verdict %0d, want %0d", out_verdict, want.verdict));
          if (out_matched !== want.matched)
            note_mismatch($sformatf("matched %0d, want %0d", out_matched, want.matched));
          if (out_match_index !== want.match_index)
            note_mismatch($sformatf("match_index %0d, want %0d",
                                    out_match_index, want.match_index));
        end
      end
      out_ready <= (hold_left == 0) && !roll_idle();
    end
  end

  // ---------------------------------------------------------------------------
  // timeout
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("ip_access_rule_first_match_tb NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [CFG_DATA_W-1:0] v4d, v6d;
    logic                  up, ud;
    int                    pick;
    v4_count     = '0;
    v6_count     = '0;
    unix_present = 1'b0;
    unix_deny    = 1'b1;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: no rules anywhere, unused mode, writes past the table
    queue_req(lookup_at(FAM_V4, rand64(), {HALF_W{1'b1}}));
    queue_req(lookup_at(FAM_V6, '0, {MAPPED_TAG, 32'h0A00_0001}));
    queue_req(lookup_at(FAM_UNIX, rand64(), rand64()));
    queue_req(lookup_at(FAM_OTHER, rand64(), rand64()));
    queue_req(rule_at(MODE_UNUSED, 6'h3F, {HALF_W{1'b1}}, {HALF_W{1'b1}},
                      {HALF_W{1'b1}}, {HALF_W{1'b1}}, 1'b1));
    queue_req(rule_at(MODE_WR_V6, 6'd63, rand64(), rand64(), rand64(), rand64(), 1'b1));
    queue_req(rule_at(MODE_WR_V6, 6'd16, rand64(), rand64(), rand64(), rand64(), 1'b0));
    // small tables: 10.1/16 allow, 10/8 deny, a rule with bits outside its mask
    queue_req(rule_at(MODE_WR_V4, 6'd0, rand64(), {32'hFFFF_FFFF, 32'h0A01_0000},
                      rand64(), {32'hFFFF_FFFF, 32'hFFFF_0000}, 1'b0));
    queue_req(rule_at(MODE_WR_V4, 6'd1, rand64(), {32'h0, 32'h0A00_0000},
                      rand64(), {32'h0, 32'hFF00_0000}, 1'b1));
    queue_req(rule_at(MODE_WR_V4, 6'd2, rand64(), {32'h0, 32'h0000_00FF},
                      rand64(), {32'h0, 32'hFFFF_FF00}, 1'b1));
    // 2001:db8::/32 deny, then ::/0 allow
    queue_req(rule_at(MODE_WR_V6, 6'd0, 64'h2001_0DB8_0000_0000, '0,
                      64'hFFFF_FFFF_0000_0000, '0, 1'b1));
    queue_req(rule_at(MODE_WR_V6, 6'd1, '0, '0, '0, '0, 1'b0));
    wait_idle();

    cfg_write(CFG_V4_COUNT, 7'd3);
    cfg_write(CFG_V6_COUNT, 7'd2);
    cfg_write(CFG_UNIX_PRESENT, 7'd1);
    cfg_write(CFG_UNIX_DENY, 7'd1);
    queue_req(lookup_at(FAM_V4, rand64(), {$urandom, 32'h0A01_0203}));
    queue_req(lookup_at(FAM_V4, rand64(), {32'h0, 32'h0A02_0304}));
    queue_req(lookup_at(FAM_V4, rand64(), {32'h0, 32'h0000_00FF}));
    queue_req(lookup_at(FAM_V6, '0, {MAPPED_TAG, 32'h0A02_0001}));
    queue_req(lookup_at(FAM_V6, '0, {MAPPED_TAG, 32'hC0A8_0001}));
    queue_req(lookup_at(FAM_V6, 64'h2001_0DB8_0000_0000, 64'h1));
    queue_req(lookup_at(FAM_V6, 64'hFE80_0000_0000_0000, 64'h1));
    queue_req(lookup_at(FAM_UNIX, rand64(), rand64()));
    wait_idle();

    // load every slot of both tables
    for (int s = 0; s < V4_N; s++) queue_req(make_rule(1'b0, SLOT_W'(s)));
    for (int s = 0; s < V6_N; s++) queue_req(make_rule(1'b1, SLOT_W'(s)));
    wait_idle();

    // random phases, first ones at the register extremes
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin v4d = 7'h7F; v6d = 7'h7F; up = 1'b1; ud = 1'b0; end  // counts saturate
        1: begin v4d = 7'd64; v6d = 7'd16; up = 1'b1; ud = 1'b1; end
        2: begin v4d = 7'd1;  v6d = 7'd1;  up = 1'b0; ud = 1'b1; end
        3: begin v4d = 7'd0;  v6d = 7'd0;  up = 1'b1; ud = 1'b0; end
        4: begin v4d = 7'd0;  v6d = 7'd16; up = 1'b0; ud = 1'b0; end  // mapped goes to v6
        default: begin
          v4d = CFG_DATA_W'($urandom_range(127));
          v6d = CFG_DATA_W'($urandom_range(127));
          up  = 1'($urandom_range(1));
          ud  = 1'($urandom_range(1));
        end
      endcase
      cfg_write(CFG_V4_COUNT, v4d);
      cfg_write(CFG_V6_COUNT, v6d);
      cfg_write(CFG_UNIX_PRESENT, {6'd0, up});
      cfg_write(CFG_UNIX_DENY, {6'd0, ud});
      if (p == 0) cfg_write(CFG_SPARE, CFG_DATA_W'($urandom_range(127)));
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        pick = $urandom_range(99);
        if (pick < 8) queue_req(make_rule(1'b0, SLOT_W'($urandom_range(63))));
        else if (pick < 13) queue_req(make_rule(1'b1, SLOT_W'($urandom_range(19))));
        else if (pick < 19) queue_req(rand_req());
        else queue_req(make_lookup());
      end
      wait_idle();
    end

    if (n_errors == 0) begin
      $display("ip_access_rule_first_match_tb OK");
    end else begin
      $display("ip_access_rule_first_match_tb NOT OK");
    end
    $finish;
  end

endmodule
